// File: sv/ncs_pkg.sv
// ncs_pkg: shared constants and types for the nearest center search block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package ncs_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int COORD_BITS  = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int DIFF_W      = COORD_BITS + 1;
  localparam int SQ_W        = 2 * COORD_BITS + 1;
  localparam int DIST_W      = 34;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [IDX_W-1:0]             idx_t;
  typedef logic [CNT_W-1:0]             cnt_t;
  typedef logic [DIST_W-1:0]            dist_t;

  // Function codes of the input channel
  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_QUERY = 1'b1
  } func_t;

  // One stored center
  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } center_t;

  // Input payload as seen by the datapath
  typedef struct packed {
    idx_t   entry_index;
    coord_t coord_x;
    coord_t coord_y;
    coord_t coord_z;
  } in_pl_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_we;      // write the center table
    logic query_start;  // latch query point, clear search
    logic scan_en;      // issue one table read
    logic out_load;     // move best match to the output register
  } ncs_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic scan_last;    // the read being issued is the final entry
    logic pipe_busy;    // distance pipeline still holds entries
    logic out_free;     // output register can take a new result
  } ncs_status_t;

endpackage

// File: sv/ncs_ifs.sv
// Channel interfaces of the nearest center search block: query/load input,
// result output and entry count configuration. Depends on ncs_pkg.
interface ncs_in_if;
  logic                valid;
  logic                ready;
  logic                func;
  ncs_pkg::idx_t       entry_index;
  ncs_pkg::coord_t     coord_x;
  ncs_pkg::coord_t     coord_y;
  ncs_pkg::coord_t     coord_z;

  modport source (output valid, func, entry_index, coord_x, coord_y, coord_z,
                  input ready);
  modport sink   (input valid, func, entry_index, coord_x, coord_y, coord_z,
                  output ready);
endinterface

interface ncs_out_if;
  logic                valid;
  logic                ready;
  ncs_pkg::idx_t       nearest_index;
  ncs_pkg::dist_t      best_distance_sq;

  modport source (output valid, nearest_index, best_distance_sq, input ready);
  modport sink   (input valid, nearest_index, best_distance_sq, output ready);
endinterface

interface ncs_cfg_if;
  logic                valid;
  logic                ready;
  ncs_pkg::cnt_t       entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink   (input valid, entry_count, output ready);
endinterface

// File: sv/ncs_ctrl.sv
// ncs_ctrl: sequencing state machine for loads and nearest-center queries.
// Depends on ncs_pkg; drives ncs_dp through ncs_cmd_t.
module ncs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_func,
  input  ncs_pkg::ncs_status_t status,
  output logic                 in_ready,
  output ncs_pkg::ncs_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt       = state_r;
    cmd.load_we     = 1'b0;
    cmd.query_start = 1'b0;
    cmd.scan_en     = 1'b0;
    cmd.out_load    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == ncs_pkg::FUNC_QUERY) begin
            cmd.query_start = 1'b1;
            state_nxt       = S_SCAN;
          end else begin
            cmd.load_we = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (status.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // A query never begins a scan while the previous one is still in flight
  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.query_start |-> !status.pipe_busy)
    else $error("query started with busy pipeline");

  // Last read of a scan is followed by the drain, never by more reads
  a_scan_stops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_en && status.scan_last |=> !cmd.scan_en && state_r == S_DRAIN)
    else $error("scan continued past last entry");

  // Results only leave once the pipeline has emptied
  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !status.pipe_busy)
    else $error("result emitted with busy pipeline");

endmodule

// File: sv/ncs_dp.sv
// ncs_dp: center table memory, squared-distance pipeline, running minimum,
// entry count register and output register. Depends on ncs_pkg.
module ncs_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ncs_pkg::ncs_cmd_t    cmd,
  input  ncs_pkg::in_pl_t      in_pl,
  input  logic                 cfg_we,
  input  ncs_pkg::cnt_t        cfg_count,
  input  logic                 out_ready,
  output ncs_pkg::ncs_status_t status,
  output logic                 out_valid,
  output ncs_pkg::idx_t        out_index,
  output ncs_pkg::dist_t       out_dist
);

  localparam int SQ_W   = ncs_pkg::SQ_W;
  localparam int DIFF_W = ncs_pkg::DIFF_W;
  localparam int DIST_W = ncs_pkg::DIST_W;
  localparam int CNT_W  = ncs_pkg::CNT_W;
  localparam int IDX_W  = ncs_pkg::IDX_W;

  // Center table
  ncs_pkg::center_t mem [ncs_pkg::MAX_ENTRIES];

  ncs_pkg::cnt_t    count_r;
  ncs_pkg::idx_t    last_idx;
  ncs_pkg::idx_t    addr_r;
  ncs_pkg::coord_t  qx_r, qy_r, qz_r;

  // Pipeline: read -> difference -> square -> sum -> compare
  logic             v1_r, v2_r, v3_r, v4_r;
  ncs_pkg::idx_t    idx1_r, idx2_r, idx3_r, idx4_r;
  ncs_pkg::center_t rd_r;
  logic signed [DIFF_W-1:0]   dx_r, dy_r, dz_r;
  logic signed [2*DIFF_W-1:0] px, py, pz;
  logic [SQ_W-1:0]  sqx_r, sqy_r, sqz_r;
  ncs_pkg::dist_t   sum_r;

  logic             best_valid_r;
  ncs_pkg::idx_t    best_idx_r;
  ncs_pkg::dist_t   best_d_r;

  logic             out_valid_r;
  ncs_pkg::idx_t    out_index_r;
  ncs_pkg::dist_t   out_dist_r;

  // Effective scan end: zero count scans slot 0, large counts saturate
  always_comb begin
    priority if (count_r == '0) begin
      last_idx = '0;
    end else if (count_r > CNT_W'(ncs_pkg::MAX_ENTRIES)) begin
      last_idx = IDX_W'(ncs_pkg::MAX_ENTRIES - 1);
    end else begin
      last_idx = IDX_W'(count_r - CNT_W'(1));
    end
  end

  assign status.scan_last = (addr_r == last_idx);
  assign status.pipe_busy = v1_r | v2_r | v3_r | v4_r;
  assign status.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(1);
    end else if (cfg_we) begin
      count_r <= cfg_count;
    end
  end

  // Table write and read ports
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      mem[in_pl.entry_index] <= '{z: in_pl.coord_z, y: in_pl.coord_y, x: in_pl.coord_x};
    end
    if (cmd.scan_en) begin
      rd_r <= mem[addr_r];
    end
  end

  // Query point and read address
  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      qx_r   <= in_pl.coord_x;
      qy_r   <= in_pl.coord_y;
      qz_r   <= in_pl.coord_z;
      addr_r <= '0;
    end else if (cmd.scan_en) begin
      addr_r <= addr_r + IDX_W'(1);
    end
  end

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.scan_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    idx1_r <= addr_r;
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    dx_r   <= {qx_r[$bits(qx_r)-1], qx_r} - {rd_r.x[$bits(qx_r)-1], rd_r.x};
    dy_r   <= {qy_r[$bits(qy_r)-1], qy_r} - {rd_r.y[$bits(qy_r)-1], rd_r.y};
    dz_r   <= {qz_r[$bits(qz_r)-1], qz_r} - {rd_r.z[$bits(qz_r)-1], rd_r.z};
    sqx_r  <= px[SQ_W-1:0];
    sqy_r  <= py[SQ_W-1:0];
    sqz_r  <= pz[SQ_W-1:0];
    sum_r  <= DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);
  end

  // Running minimum; strict compare keeps the lower index on ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
    end else if (cmd.query_start) begin
      best_valid_r <= 1'b0;
    end else if (v4_r) begin
      best_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (v4_r && (!best_valid_r || sum_r < best_d_r)) begin
      best_d_r   <= sum_r;
      best_idx_r <= idx4_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index_r <= best_idx_r;
      out_dist_r  <= best_d_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_dist  = out_dist_r;

  // A result always carries at least one compared entry
  a_best_seen: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> best_valid_r)
    else $error("result emitted before any distance compared");

  // Stages advance in lockstep
  a_pipe_shift: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> $past(v1_r))
    else $error("pipeline valid skipped a stage");

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_index_r))
    else $error("pending result lost");

endmodule

// File: sv/nearest_center_search.sv
// nearest_center_search: top level of the nearest center search block.
// Depends on ncs_pkg, the channel interfaces, ncs_ctrl and ncs_dp.
//
//   channel  | dir | payload                                        | notes
//   ---------+-----+------------------------------------------------+-----------------
//   in_if    | in  | func, entry_index, coord_x, coord_y, coord_z    | load or query
//   out_if   | out | nearest_index, best_distance_sq                 | one per query
//   cfg_if   | in  | entry_count                                     | always ready
//
// Sequencing: a load is written as it is taken and the next transaction may
// follow at once. A query's result goes to the output register once the scan and
// the pipeline are done and the register is free; the input then takes the next
// transaction. Slot 0 alone is scanned when entry_count is zero, 256 slots when
// above 256. The scan makes one table read per cycle on the single read port,
// then passes four distance pipeline stages, a drain state and an emit state.
// Reset: entry_count returns to 1; the center table is not cleared and holds
// garbage until loaded. Stalls: a finished result waits in the output register;
// while it waits, loads are still taken, and a new query scans but holds its
// result until the register frees up.
module nearest_center_search (
  input  logic      clk,
  input  logic      rst_n,
  ncs_in_if.sink    in_if,
  ncs_out_if.source out_if,
  ncs_cfg_if.sink   cfg_if
);

  ncs_pkg::ncs_cmd_t    cmd;
  ncs_pkg::ncs_status_t status;
  ncs_pkg::in_pl_t      in_pl;

  // Entry count always writable; user must write it only when idle; not enforced
  assign cfg_if.ready = 1'b1;

  assign in_pl.entry_index = in_if.entry_index;
  assign in_pl.coord_x     = in_if.coord_x;
  assign in_pl.coord_y     = in_if.coord_y;
  assign in_pl.coord_z     = in_if.coord_z;

  ncs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_func  (in_if.func),
    .status   (status),
    .in_ready (in_if.ready),
    .cmd      (cmd)
  );

  ncs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_pl     (in_pl),
    .cfg_we    (cfg_if.valid),
    .cfg_count (cfg_if.entry_count),
    .out_ready (out_if.ready),
    .status    (status),
    .out_valid (out_if.valid),
    .out_index (out_if.nearest_index),
    .out_dist  (out_if.best_distance_sq)
  );

endmodule
